### design/qaom_pkg.sv
// ----------------------------------------------------------------------------
// qaom_pkg
// Shared widths, register indexes, control struct and clamp helpers for the
// four-channel attenuverter/offset mixer.
// ----------------------------------------------------------------------------
package qaom_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int CH_COUNT       = 4;
   localparam int KNOB_BITS      = 13;
   localparam int KNOB_ONE       = 4096;
   localparam int GAIN_BITS      = KNOB_BITS + 2;
   localparam int OFFSET_MULT    = 19;
   localparam int OFFS_BITS      = GAIN_BITS + 5;
   localparam int OFFS_SHIFT     = 10;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
   localparam int ACC_BITS       = ((PROD_BITS > OFFS_BITS + OFFS_SHIFT) ?
                                    PROD_BITS : OFFS_BITS + OFFS_SHIFT) + 1;
   localparam int FRAC_BITS      = 12;
   localparam int ROUND_HALF     = 1 << (FRAC_BITS - 1);
   localparam int V_BITS         = ACC_BITS - FRAC_BITS;
   localparam int MIX_BITS       = V_BITS + 2;
   localparam int OUT_BITS       = 16;
   localparam int POS_BITS       = 15;
   localparam int POS_SUM_BITS   = POS_BITS + 2;
   localparam int NEG_SUM_BITS   = OUT_BITS + 2;
   localparam int VOLT_LIMIT     = 20480;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCALE_CH1,
      CSR_SHIFT_CH1,
      CSR_SCALE_CH2,
      CSR_SHIFT_CH2,
      CSR_SCALE_CH3,
      CSR_SHIFT_CH3,
      CSR_SCALE_CH4,
      CSR_SHIFT_CH4
   } csr_index_type;

   // per-stage load strobes for the channel datapath
   typedef struct packed {
      logic load_mult;
      logic load_sum;
   } stage_ctrl_type;

   // symmetric clamp to +-10 V
   function automatic logic signed [OUT_BITS-1:0] clamp_volt(
      input logic signed [MIX_BITS-1:0] x);
      logic signed [OUT_BITS-1:0] r;
      if (x > $signed(MIX_BITS'(VOLT_LIMIT)))
         r = OUT_BITS'(VOLT_LIMIT);
      else if (x < -$signed(MIX_BITS'(VOLT_LIMIT)))
         r = -$signed(OUT_BITS'(VOLT_LIMIT));
      else
         r = OUT_BITS'(x);
      return r;
   endfunction

   function automatic logic [POS_BITS-1:0] clamp_pos(
      input logic [POS_SUM_BITS-1:0] x);
      logic [POS_BITS-1:0] r;
      if (x > POS_SUM_BITS'(VOLT_LIMIT))
         r = POS_BITS'(VOLT_LIMIT);
      else
         r = POS_BITS'(x);
      return r;
   endfunction

   function automatic logic signed [OUT_BITS-1:0] clamp_neg(
      input logic signed [NEG_SUM_BITS-1:0] x);
      logic signed [OUT_BITS-1:0] r;
      if (x < -$signed(NEG_SUM_BITS'(VOLT_LIMIT)))
         r = -$signed(OUT_BITS'(VOLT_LIMIT));
      else
         r = OUT_BITS'(x);
      return r;
   endfunction

endpackage

### design/qaom_channel.sv
// ----------------------------------------------------------------------------
// qaom_channel
// One channel datapath: gain multiply and offset in one stage, rounded sum
// in the next.
// ----------------------------------------------------------------------------
module qaom_channel import qaom_pkg::*; (
   input  logic                          clock,
   input  stage_ctrl_type                ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [KNOB_BITS-1:0]   scale,
   input  logic        [KNOB_BITS-1:0]   shift,
   output logic signed [V_BITS-1:0]      value
);

   logic signed [GAIN_BITS-1:0] gain;
   logic signed [GAIN_BITS-1:0] offs_knob;
   logic signed [OFFS_BITS-1:0] offs_in;
   logic signed [OFFS_BITS-1:0] offs_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc;
   logic signed [V_BITS-1:0]    value_in;
   logic signed [V_BITS-1:0]    value_ff;

   // 2*k - 1.0 in Q12
   assign gain      = $signed({1'b0, scale, 1'b0}) - $signed(GAIN_BITS'(KNOB_ONE));
   assign offs_knob = $signed({1'b0, shift, 1'b0}) - $signed(GAIN_BITS'(KNOB_ONE));

   assign prod_in = sample * gain;
   assign offs_in = OFFS_BITS'(offs_knob) * $signed(OFFS_BITS'(OFFSET_MULT));

   // exact value in 1/4096 LSB, plus half for round-half-up, then floor
   assign acc = ACC_BITS'(prod_ff)
              + ACC_BITS'($signed({offs_ff, OFFS_SHIFT'(0)}))
              + $signed(ACC_BITS'(ROUND_HALF));
   assign value_in = acc[ACC_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctrl.load_mult) begin
         prod_ff <= prod_in;
         offs_ff <= offs_in;
      end
      if (ctrl.load_sum) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

### design/quad_attenuverter_offset_mixer.sv
// ----------------------------------------------------------------------------
// quad_attenuverter_offset_mixer
// Four-channel attenuverter with offset, per-channel clamp and four mix sums.
// ----------------------------------------------------------------------------
// One frame per clock, sustained while rsp_ready is high. A transaction passes
// four register stages (normalling capture, gain multiply, rounded offset
// sum, clamp and mix); rsp_valid is driven from the valid bit of the last.
// The stages form a stall-able pipeline: each stage loads when it is empty
// or the stage after it moves, so a stalled output holds its transaction and
// bubbles are squeezed out. The user is to write the knob registers through
// the csr port only while the pipeline is empty; the block itself does not
// enforce it. Values are in Q12 (4096 = 1.0), gain is 2k-1 and the offset
// is (2k-1)*9.5 V. Samples and results are 2048 LSB per volt.
// Unpatched inputs 1 and 3 read 0, unpatched 2 follows 1 and 4 follows 3.
// ----------------------------------------------------------------------------
module quad_attenuverter_offset_mixer import qaom_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   // input frames
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_ch1,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_ch2,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_ch3,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_ch4,
   input  logic        [CH_COUNT-1:0]     req_inputs_patched,
   input  logic        [CH_COUNT-1:0]     req_outputs_patched,
   // results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_BITS-1:0]     rsp_out_ch1,
   output logic signed [OUT_BITS-1:0]     rsp_out_ch2,
   output logic signed [OUT_BITS-1:0]     rsp_out_ch3,
   output logic signed [OUT_BITS-1:0]     rsp_out_ch4,
   output logic        [POS_BITS-1:0]     rsp_positive_slice,
   output logic signed [OUT_BITS-1:0]     rsp_negative_slice,
   output logic signed [OUT_BITS-1:0]     rsp_mix_all,
   output logic signed [OUT_BITS-1:0]     rsp_mix_unpatched,
   // knob registers
   input  logic                           csr_we,
   input  logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [KNOB_BITS-1:0]    csr_wdata
);

   // ---------------------------------------------------------------- knobs
   logic [KNOB_BITS-1:0] scale_ff [CH_COUNT];
   logic [KNOB_BITS-1:0] shift_ff [CH_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CH_COUNT; i++) begin
            scale_ff[i] <= KNOB_BITS'(KNOB_ONE / 2);
            shift_ff[i] <= KNOB_BITS'(KNOB_ONE / 2);
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE_CH1: scale_ff[0] <= csr_wdata;
            CSR_SHIFT_CH1: shift_ff[0] <= csr_wdata;
            CSR_SCALE_CH2: scale_ff[1] <= csr_wdata;
            CSR_SHIFT_CH2: shift_ff[1] <= csr_wdata;
            CSR_SCALE_CH3: scale_ff[2] <= csr_wdata;
            CSR_SHIFT_CH3: shift_ff[2] <= csr_wdata;
            CSR_SCALE_CH4: scale_ff[3] <= csr_wdata;
            CSR_SHIFT_CH4: shift_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------- pipeline control
   // Stage 1: normalled samples, 2: product/offset, 3: channel value,
   // 4: output register.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic ready1, ready2, ready3, ready4;
   stage_ctrl_type ctrl;

   assign ready4 = !valid4_ff || rsp_ready;
   assign ready3 = !valid3_ff || ready4;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;

   assign req_ready      = ready1;
   assign ctrl.load_mult = ready2;
   assign ctrl.load_sum  = ready3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= req_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
         if (ready4) valid4_ff <= valid3_ff;
      end
   end

   // ------------------------------------------------- stage 1: normalling
   logic signed [SAMPLE_BITS-1:0] x_in [CH_COUNT];
   logic signed [SAMPLE_BITS-1:0] x_ff [CH_COUNT];
   logic [CH_COUNT-1:0] outp1_ff, outp2_ff, outp3_ff;

   always_comb begin
      x_in[0] = req_inputs_patched[0] ? req_sample_ch1 : '0;
      x_in[1] = req_inputs_patched[1] ? req_sample_ch2 : x_in[0];
      x_in[2] = req_inputs_patched[2] ? req_sample_ch3 : '0;
      x_in[3] = req_inputs_patched[3] ? req_sample_ch4 : x_in[2];
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         x_ff     <= x_in;
         outp1_ff <= req_outputs_patched;
      end
      // jack mask rides alongside the channel datapath
      if (ready2) outp2_ff <= outp1_ff;
      if (ready3) outp3_ff <= outp2_ff;
   end

   // --------------------------------------------- stages 2-3: per channel
   logic signed [V_BITS-1:0] chan_v [CH_COUNT];

   for (genvar ch = 0; ch < CH_COUNT; ch++) begin : g_chan
      qaom_channel u_chan (
         .clock  (clock),
         .ctrl   (ctrl),
         .sample (x_ff[ch]),
         .scale  (scale_ff[ch]),
         .shift  (shift_ff[ch]),
         .value  (chan_v[ch])
      );
   end

   // ------------------------------------------- stage 4: clamp and mixing
   logic signed [OUT_BITS-1:0]     out_in [CH_COUNT];
   logic        [POS_SUM_BITS-1:0] pos_sum;
   logic signed [NEG_SUM_BITS-1:0] neg_sum;
   logic signed [MIX_BITS-1:0]     mix_sum;
   logic signed [MIX_BITS-1:0]     mixu_sum;

   // slices use the per-channel clamp, mixes the raw channel values
   always_comb begin
      pos_sum  = '0;
      neg_sum  = '0;
      mix_sum  = '0;
      mixu_sum = '0;
      for (int i = 0; i < CH_COUNT; i++) begin
         out_in[i] = clamp_volt(MIX_BITS'(chan_v[i]));
         if (out_in[i] > 0)
            pos_sum = pos_sum + POS_SUM_BITS'(out_in[i][POS_BITS-1:0]);
         else
            neg_sum = neg_sum + NEG_SUM_BITS'(out_in[i]);
         mix_sum = mix_sum + MIX_BITS'(chan_v[i]);
         if (!outp3_ff[i])
            mixu_sum = mixu_sum + MIX_BITS'(chan_v[i]);
      end
   end

   logic signed [OUT_BITS-1:0] out_ff [CH_COUNT];
   logic        [POS_BITS-1:0] pos_ff;
   logic signed [OUT_BITS-1:0] neg_ff;
   logic signed [OUT_BITS-1:0] mix_ff;
   logic signed [OUT_BITS-1:0] mixu_ff;

   always_ff @(posedge clock) begin
      if (ready4) begin
         out_ff  <= out_in;
         pos_ff  <= clamp_pos(pos_sum);
         neg_ff  <= clamp_neg(neg_sum);
         mix_ff  <= clamp_volt(mix_sum);
         mixu_ff <= clamp_volt(mixu_sum);
      end
   end

   assign rsp_valid          = valid4_ff;
   assign rsp_out_ch1        = out_ff[0];
   assign rsp_out_ch2        = out_ff[1];
   assign rsp_out_ch3        = out_ff[2];
   assign rsp_out_ch4        = out_ff[3];
   assign rsp_positive_slice = pos_ff;
   assign rsp_negative_slice = neg_ff;
   assign rsp_mix_all        = mix_ff;
   assign rsp_mix_unpatched  = mixu_ff;

`ifndef SYNTHESIS
   // a free output side must open the whole pipe
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_ch1 <= $signed(OUT_BITS'(VOLT_LIMIT)))
                 && (rsp_out_ch1 >= -$signed(OUT_BITS'(VOLT_LIMIT)))
                 && (rsp_mix_all <= $signed(OUT_BITS'(VOLT_LIMIT)))
                 && (rsp_mix_all >= -$signed(OUT_BITS'(VOLT_LIMIT))))
      else $error("channel or mix result outside +-10 V");

   a_slice_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_positive_slice <= POS_BITS'(VOLT_LIMIT))
                 && (rsp_negative_slice <= 0))
      else $error("slice result out of range");
`endif

endmodule
